// ===== rtl/kwbq_pkg.sv =====
// ============================================================================
// kwbq_pkg: shared types, constants and microcode for the K-weighting filter
// Holds the control word layout, the operand and operation codes, the
// coefficient reset set and the microcode program of the sequencer.
// ============================================================================
`default_nettype none

package kwbq_pkg;

    localparam int SAMPLE_W_DEF  = 24;
    localparam int COEF_FRAC_DEF = 28;
    localparam int COEF_W        = 32;
    localparam int NUM_COEF      = 7;
    localparam int CFG_IDX_W     = 3;
    localparam int ACC_W         = 64;
    localparam int MULC_W        = COEF_W + 1;
    localparam int NUM_STEPS     = 15;
    localparam int STEP_W        = 4;

    // Coefficient register indexes on the configuration channel.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRE_B0 = 3'd0,
        REG_PRE_B1 = 3'd1,
        REG_PRE_B2 = 3'd2,
        REG_PRE_A1 = 3'd3,
        REG_PRE_A2 = 3'd4,
        REG_HP_A1  = 3'd5,
        REG_HP_A2  = 3'd6
    } reg_idx_t;

    typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_bank_t;

    // Standard 48 kHz coefficient set in Q3.28.
    localparam longint RESET_Q28 [NUM_COEF] = '{
        412081942, -722546694, 321691121, -453832898,
        196623811, -534199296, 265770496
    };

    // Multiplier sample operand select.
    typedef enum logic [3:0] {
        A_X,
        A_PIN0,
        A_PIN1,
        A_POUT0,
        A_POUT1,
        A_YPRE,
        A_HIN0,
        A_HIN1,
        A_HOUT0,
        A_HOUT1
    } a_sel_t;

    // Multiplier coefficient operand select.
    typedef enum logic [3:0] {
        C_PRE_B0,
        C_PRE_B1,
        C_PRE_B2,
        C_PRE_A1,
        C_PRE_A2,
        C_HP_A1,
        C_HP_A2,
        C_ONE,
        C_TWO
    } c_sel_t;

    typedef enum logic [2:0] {
        ACC_NOP,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB,
        ACC_RND
    } acc_op_t;

    // Condition under which a step advances; otherwise it repeats.
    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN,
        COND_OUT
    } cond_t;

    typedef struct packed {
        a_sel_t  a_sel;
        c_sel_t  c_sel;
        logic    mul_en;
        acc_op_t acc_op;
        cond_t   cond;
        logic    commit;
        logic    last;
    } ucode_t;

    typedef struct packed {
        ucode_t uc;
        logic   adv;
    } seq_ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } seq_stat_t;

    // Reset coefficient rescaled to the chosen number of fraction bits.
    function automatic logic [COEF_W-1:0] reset_coef(input int idx, input int frac);
        longint c;
        longint hi;
        longint lo;
        c  = RESET_Q28[idx];
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (frac >= 28) begin
            c = c <<< (frac - 28);
        end
        else begin
            c = (c + (64'sd1 <<< (27 - frac))) >>> (28 - frac);
        end
        if (c > hi) begin
            c = hi;
        end
        if (c < lo) begin
            c = lo;
        end
        return c[COEF_W-1:0];
    endfunction

    function automatic ucode_t uw(input a_sel_t a, input c_sel_t c, input logic m,
                                  input acc_op_t op, input cond_t cd,
                                  input logic cm, input logic l);
        ucode_t w;
        w.a_sel  = a;
        w.c_sel  = c;
        w.mul_en = m;
        w.acc_op = op;
        w.cond   = cd;
        w.commit = cm;
        w.last   = l;
        return w;
    endfunction

    // Microcode program. The multiplier result is registered, so the
    // accumulator consumes a product one step after it was started.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            4'd0:  w = uw(A_X,     C_ONE,    1'b0, ACC_NOP,  COND_IN,     1'b0, 1'b0);
            4'd1:  w = uw(A_X,     C_PRE_B0, 1'b1, ACC_NOP,  COND_ALWAYS, 1'b0, 1'b0);
            4'd2:  w = uw(A_PIN0,  C_PRE_B1, 1'b1, ACC_LOAD, COND_ALWAYS, 1'b0, 1'b0);
            4'd3:  w = uw(A_PIN1,  C_PRE_B2, 1'b1, ACC_ADD,  COND_ALWAYS, 1'b0, 1'b0);
            4'd4:  w = uw(A_POUT0, C_PRE_A1, 1'b1, ACC_ADD,  COND_ALWAYS, 1'b0, 1'b0);
            4'd5:  w = uw(A_POUT1, C_PRE_A2, 1'b1, ACC_SUB,  COND_ALWAYS, 1'b0, 1'b0);
            4'd6:  w = uw(A_X,     C_ONE,    1'b0, ACC_SUB,  COND_ALWAYS, 1'b0, 1'b0);
            4'd7:  w = uw(A_X,     C_ONE,    1'b0, ACC_RND,  COND_ALWAYS, 1'b0, 1'b0);
            4'd8:  w = uw(A_YPRE,  C_ONE,    1'b1, ACC_NOP,  COND_ALWAYS, 1'b0, 1'b0);
            4'd9:  w = uw(A_HIN0,  C_TWO,    1'b1, ACC_LOAD, COND_ALWAYS, 1'b0, 1'b0);
            4'd10: w = uw(A_HIN1,  C_ONE,    1'b1, ACC_SUB,  COND_ALWAYS, 1'b0, 1'b0);
            4'd11: w = uw(A_HOUT0, C_HP_A1,  1'b1, ACC_ADD,  COND_ALWAYS, 1'b0, 1'b0);
            4'd12: w = uw(A_HOUT1, C_HP_A2,  1'b1, ACC_SUB,  COND_ALWAYS, 1'b0, 1'b0);
            4'd13: w = uw(A_X,     C_ONE,    1'b0, ACC_SUB,  COND_ALWAYS, 1'b0, 1'b0);
            4'd14: w = uw(A_X,     C_ONE,    1'b0, ACC_RND,  COND_OUT,    1'b1, 1'b1);
            default: w = uw(A_X,   C_ONE,    1'b0, ACC_NOP,  COND_ALWAYS, 1'b0, 1'b1);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/kwbq_in_if.sv =====
// ============================================================================
// kwbq_in_if: sample input channel
// Valid/ready channel carrying one signed PCM sample per item.
// ============================================================================
`default_nettype none

interface kwbq_in_if #(
    parameter int WIDTH = kwbq_pkg::SAMPLE_W_DEF
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] audio_in;

    modport source (output valid, output audio_in, input ready);
    modport sink   (input valid, input audio_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/kwbq_out_if.sv =====
// ============================================================================
// kwbq_out_if: weighted sample output channel
// Valid/ready channel carrying one K-weighted sample per item.
// ============================================================================
`default_nettype none

interface kwbq_out_if #(
    parameter int WIDTH = kwbq_pkg::SAMPLE_W_DEF
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] weighted_out;

    modport source (output valid, output weighted_out, input ready);
    modport sink   (input valid, input weighted_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/kwbq_cfg_if.sv =====
// ============================================================================
// kwbq_cfg_if: coefficient write channel
// Valid/ready channel carrying a register index and its write data.
// ============================================================================
`default_nettype none

interface kwbq_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [kwbq_pkg::CFG_IDX_W-1:0]      index;
    logic [kwbq_pkg::COEF_W-1:0]         data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/k_weighting_biquad_cascade_core.sv =====
// ============================================================================
// k_weighting_biquad_cascade_core: K-weighting filter, two biquad cascade
// Shelving pre-filter followed by a high-pass stage, run by a microcoded
// sequencer over one shared multiplier and one saturating accumulator.
// ============================================================================
// Usage:
// The sample channel takes one signed PCM sample per item; the result
// channel gives one K-weighted, saturated sample per item. The configuration
// channel writes one of seven coefficients per handshake: indexes 0 to 4 are
// the pre-filter taps b0, b1, b2, a1, a2 and 5 and 6 the high-pass taps a1,
// a2. Writes to other indexes are dropped, and writes are only to be made
// while no item is in flight.
// Timing: the program has 15 steps, one per clock while no step waits. An
// item is accepted in the first step and its result enters the output
// register in the last; the next item can be accepted in the cycle after
// that, so the block takes no new item before it is through with the last.
// The program length is set by the single multiplier, which forms the ten
// products of both stages one per cycle, plus the two steps that subtract
// the last product of each stage, the two rounding steps and the input step.
// Reset clears the filter histories and loads the standard 48 kHz
// coefficient set, rescaled to the chosen number of fraction bits.
// A result waits in the output register until it is taken; a new item is
// accepted and computed meanwhile, and the final step holds if the previous
// result is still waiting.
// ============================================================================
`default_nettype none

module k_weighting_biquad_cascade_core #(
    parameter int SAMPLE_WIDTH   = kwbq_pkg::SAMPLE_W_DEF,
    parameter int COEF_FRAC_BITS = kwbq_pkg::COEF_FRAC_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    kwbq_in_if.sink      sample_ch,
    kwbq_out_if.source   result_ch,
    kwbq_cfg_if.sink     cfg
);
    import kwbq_pkg::*;

    coef_bank_t coef;
    seq_ctrl_t  ctrl;
    seq_stat_t  stat;
    logic       in_ready;
    logic       out_free;
    logic       out_valid;
    logic       cfg_ready;
    logic signed [SAMPLE_WIDTH-1:0] weighted_out;

    // Coefficient registers behind the configuration channel.
    kwbq_coef_bank #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_coef_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_ready (cfg_ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .coef     (coef)
    );

    // The sequencer waits for an input item in its first step and for a
    // free output slot in its last.
    assign stat.in_valid = sample_ch.valid;
    assign stat.out_free = out_free;

    kwbq_ucode_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .ctrl     (ctrl),
        .in_ready (in_ready)
    );

    kwbq_datapath #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .coef         (coef),
        .audio_in     (sample_ch.audio_in),
        .out_ready    (result_ch.ready),
        .out_valid    (out_valid),
        .weighted_out (weighted_out),
        .out_free     (out_free)
    );

    assign sample_ch.ready        = in_ready;
    assign cfg.ready              = cfg_ready;
    assign result_ch.valid        = out_valid;
    assign result_ch.weighted_out = weighted_out;

endmodule

`default_nettype wire

// ===== rtl/kwbq_coef_bank.sv =====
// ============================================================================
// kwbq_coef_bank: programmable coefficient registers
// Seven signed coefficients, reset to the standard set and written one
// at a time through the configuration channel.
// ============================================================================
`default_nettype none

module kwbq_coef_bank #(
    parameter int COEF_FRAC_BITS = kwbq_pkg::COEF_FRAC_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_valid,
    output logic                                wr_ready,
    input  wire logic [kwbq_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [kwbq_pkg::COEF_W-1:0]    wr_data,
    output kwbq_pkg::coef_bank_t                coef
);
    import kwbq_pkg::*;

    coef_bank_t coef_reg;
    coef_bank_t coef_next;

    assign wr_ready = 1'b1;

    // Writes to an index past the last register are dropped.
    always_comb begin
        coef_next = coef_reg;
        if (wr_valid && (32'(wr_index) < NUM_COEF)) begin
            coef_next[wr_index] = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                coef_reg[i] <= reset_coef(i, COEF_FRAC_BITS);
            end
        end
        else begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

`default_nettype wire

// ===== rtl/kwbq_ucode_seq.sv =====
// ============================================================================
// kwbq_ucode_seq: microcode sequencer
// Step counter addressing the control store, with hold conditions for
// input arrival and output slot availability.
// ============================================================================
`default_nettype none

module kwbq_ucode_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire kwbq_pkg::seq_stat_t stat,
    output kwbq_pkg::seq_ctrl_t      ctrl,
    output logic                     in_ready
);
    import kwbq_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_t            uc;
    logic              adv;

    assign uc = ucode_rom(step_reg);

    always_comb begin
        case (uc.cond)
            COND_ALWAYS: adv = 1'b1;
            COND_IN:     adv = stat.in_valid;
            COND_OUT:    adv = stat.out_free;
            default:     adv = 1'b1;
        endcase
    end

    always_comb begin
        step_next = step_reg;
        if (adv) begin
            step_next = uc.last ? '0 : step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            step_reg <= '0;
        end
        else begin
            step_reg <= step_next;
        end
    end

    assign ctrl.uc  = uc;
    assign ctrl.adv = adv;
    assign in_ready = (uc.cond == COND_IN);

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(step_reg) < NUM_STEPS)
        else $error("step counter outside program");

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(step_reg))
        else $error("step moved while its condition was false");

    a_start_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && stat.in_valid) |=> (step_reg == STEP_W'(1)))
        else $error("sequence did not start after an accepted item");

endmodule

`default_nettype wire

// ===== rtl/kwbq_datapath.sv =====
// ============================================================================
// kwbq_datapath: shared multiply-accumulate datapath
// One registered multiplier, a saturating 64-bit accumulator with
// rounding, the filter histories and the output register.
// ============================================================================
`default_nettype none

module kwbq_datapath #(
    parameter int SAMPLE_WIDTH   = kwbq_pkg::SAMPLE_W_DEF,
    parameter int COEF_FRAC_BITS = kwbq_pkg::COEF_FRAC_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire kwbq_pkg::seq_ctrl_t            ctrl,
    input  wire kwbq_pkg::coef_bank_t           coef,
    input  wire logic signed [SAMPLE_WIDTH-1:0] audio_in,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]      weighted_out,
    output logic                                out_free
);
    import kwbq_pkg::*;

    localparam logic signed [ACC_W-1:0]  RND_HALF  = 64'sd1 <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [MULC_W-1:0] C_ONE_VAL = 33'sd1 <<< COEF_FRAC_BITS;
    localparam logic signed [MULC_W-1:0] C_TWO_VAL = 33'sd1 <<< (COEF_FRAC_BITS + 1);
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [COEF_W-1:0] Y_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] Y_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] pin0_reg, pin1_reg;
    logic signed [COEF_W-1:0]       pout0_reg, pout1_reg;
    logic signed [COEF_W-1:0]       hin0_reg, hin1_reg;
    logic signed [COEF_W-1:0]       hout0_reg, hout1_reg;
    logic signed [COEF_W-1:0]       ypre_reg;
    logic signed [ACC_W-1:0]        prod_reg;
    logic signed [ACC_W-1:0]        acc_reg, acc_next;
    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] out_data_reg;

    logic signed [COEF_W-1:0]  a_op;
    logic signed [MULC_W-1:0]  c_op;
    logic signed [ACC_W:0]     prod_full;
    logic signed [ACC_W-1:0]   opnd;
    logic [ACC_W:0]            sum_wide;
    logic signed [ACC_W-1:0]   sat_sum;
    logic signed [ACC_W-1:0]   shifted;
    logic signed [COEF_W-1:0]  rnd32;
    logic [SAMPLE_WIDTH-1:0]   y_sat;
    logic                      do_commit;
    logic                      take_in;

    assign do_commit = ctrl.adv && ctrl.uc.commit;
    assign take_in   = ctrl.adv && (ctrl.uc.cond == COND_IN);

    always_comb begin
        case (ctrl.uc.a_sel)
            A_X:     a_op = COEF_W'(x_reg);
            A_PIN0:  a_op = COEF_W'(pin0_reg);
            A_PIN1:  a_op = COEF_W'(pin1_reg);
            A_POUT0: a_op = pout0_reg;
            A_POUT1: a_op = pout1_reg;
            A_YPRE:  a_op = ypre_reg;
            A_HIN0:  a_op = hin0_reg;
            A_HIN1:  a_op = hin1_reg;
            A_HOUT0: a_op = hout0_reg;
            A_HOUT1: a_op = hout1_reg;
            default: a_op = '0;
        endcase
    end

    always_comb begin
        case (ctrl.uc.c_sel)
            C_PRE_B0: c_op = {coef[REG_PRE_B0][COEF_W-1], coef[REG_PRE_B0]};
            C_PRE_B1: c_op = {coef[REG_PRE_B1][COEF_W-1], coef[REG_PRE_B1]};
            C_PRE_B2: c_op = {coef[REG_PRE_B2][COEF_W-1], coef[REG_PRE_B2]};
            C_PRE_A1: c_op = {coef[REG_PRE_A1][COEF_W-1], coef[REG_PRE_A1]};
            C_PRE_A2: c_op = {coef[REG_PRE_A2][COEF_W-1], coef[REG_PRE_A2]};
            C_HP_A1:  c_op = {coef[REG_HP_A1][COEF_W-1], coef[REG_HP_A1]};
            C_HP_A2:  c_op = {coef[REG_HP_A2][COEF_W-1], coef[REG_HP_A2]};
            C_ONE:    c_op = C_ONE_VAL;
            C_TWO:    c_op = C_TWO_VAL;
            default:  c_op = '0;
        endcase
    end

    // A 32 x 33 signed product always fits in 64 bits.
    assign prod_full = (ACC_W+1)'(a_op) * (ACC_W+1)'(c_op);

    // Saturating add or subtract; rounding adds half an LSB of the result.
    always_comb begin
        opnd = (ctrl.uc.acc_op == ACC_RND) ? RND_HALF : prod_reg;
        if (ctrl.uc.acc_op == ACC_SUB) begin
            sum_wide = {acc_reg[ACC_W-1], acc_reg} - {opnd[ACC_W-1], opnd};
        end
        else begin
            sum_wide = {acc_reg[ACC_W-1], acc_reg} + {opnd[ACC_W-1], opnd};
        end
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
            sat_sum = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else begin
            sat_sum = sum_wide[ACC_W-1:0];
        end
        shifted = sat_sum >>> COEF_FRAC_BITS;
        if ((&shifted[ACC_W-1:COEF_W-1]) || !(|shifted[ACC_W-1:COEF_W-1])) begin
            rnd32 = shifted[COEF_W-1:0];
        end
        else begin
            rnd32 = shifted[ACC_W-1] ? Y_MIN : Y_MAX;
        end
        if ((&rnd32[COEF_W-1:SAMPLE_WIDTH-1]) || !(|rnd32[COEF_W-1:SAMPLE_WIDTH-1])) begin
            y_sat = rnd32[SAMPLE_WIDTH-1:0];
        end
        else begin
            y_sat = rnd32[COEF_W-1] ? S_MIN : S_MAX;
        end
    end

    always_comb begin
        case (ctrl.uc.acc_op)
            ACC_LOAD: acc_next = prod_reg;
            ACC_ADD:  acc_next = sat_sum;
            ACC_SUB:  acc_next = sat_sum;
            default:  acc_next = acc_reg;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (do_commit) begin
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Working registers, no reset needed.
    always_ff @(posedge clk) begin
        if (take_in) begin
            x_reg <= audio_in;
        end
        if (ctrl.adv && ctrl.uc.mul_en) begin
            prod_reg <= prod_full[ACC_W-1:0];
        end
        if (ctrl.adv) begin
            acc_reg <= acc_next;
        end
        if (ctrl.adv && (ctrl.uc.acc_op == ACC_RND) && !ctrl.uc.commit) begin
            ypre_reg <= rnd32;
        end
        if (do_commit) begin
            out_data_reg <= y_sat;
        end
    end

    // Filter histories start from zero.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pin0_reg      <= '0;
            pin1_reg      <= '0;
            pout0_reg     <= '0;
            pout1_reg     <= '0;
            hin0_reg      <= '0;
            hin1_reg      <= '0;
            hout0_reg     <= '0;
            hout1_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
            if (do_commit) begin
                pin1_reg  <= pin0_reg;
                pin0_reg  <= x_reg;
                pout1_reg <= pout0_reg;
                pout0_reg <= ypre_reg;
                hin1_reg  <= hin0_reg;
                hin0_reg  <= ypre_reg;
                hout1_reg <= hout0_reg;
                hout0_reg <= rnd32;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign weighted_out = out_data_reg;
    assign out_free     = !out_valid_reg || out_ready;

    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        do_commit |-> (!out_valid_reg || out_ready))
        else $error("result written over one not yet taken");

    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(do_commit))
        else $error("output valid rose without a committed result");

    a_commit_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        do_commit |-> (ctrl.uc.acc_op == ACC_RND))
        else $error("commit step does not round the accumulator");

    a_hist_copies_agree: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> (hin0_reg == pout0_reg) && (hin1_reg == pout1_reg))
        else $error("stage histories diverged");

endmodule

`default_nettype wire

// ===== tb/tb_k_weighting_biquad_cascade_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_k_weighting_biquad_cascade_core: self-checking bench for the K filter
// Sends signed PCM items through the two-stage K-weighting cascade and checks
// every weighted item against a bit-true predictor of the fixed-point filter.
// The run goes through several coefficient sets, among them the standard set,
// all-maximum and all-minimum taps, with random gaps and stalls on the item
// channels.
// ============================================================================

module tb_k_weighting_biquad_cascade_core;

    import kwbq_pkg::*;

    localparam int SW   = SAMPLE_W_DEF;
    localparam int FRAC = COEF_FRAC_DEF;

    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

    localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;

    // Index 7 has no register behind it; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    // Shapes of the random item stream.
    typedef enum int {
        PAT_NOISE,
        PAT_QUIET,
        PAT_EDGE,
        PAT_STEP,
        PAT_NYQUIST
    } sample_pattern_t;

    logic clk = 1'b0;
    logic rst_n;

    kwbq_in_if  #(.WIDTH(SW)) sample_bus ();
    kwbq_out_if #(.WIDTH(SW)) result_bus ();
    kwbq_cfg_if               cfg_bus ();

    k_weighting_biquad_cascade_core #(
        .SAMPLE_WIDTH  (SW),
        .COEF_FRAC_BITS(FRAC)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample_ch(sample_bus),
        .result_ch(result_bus),
        .cfg      (cfg_bus)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------

    // PCM items waiting to be offered, and weighted items still owed by the
    // block, oldest first.
    logic signed [SW-1:0] samples_to_send[$];
    logic signed [SW-1:0] expected_weighted[$];

    // The bench's copy of the coefficient bank and of the four histories.
    longint coef_q[NUM_COEF];
    longint pre_x_d[2];
    longint pre_y_d[2];
    longint hp_x_d[2];
    longint hp_y_d[2];

    // The sender holds off while the main sequence fills the item queue or
    // rewrites coefficients. Gap and stall limits are set per phase.
    logic        send_hold;
    int unsigned send_gap_max;
    int unsigned sink_stall_max;
    int unsigned send_gap;
    int unsigned sink_hold_cycles;
    int unsigned failures;

    // ------------------------------------------------------------------------
    // Fixed-point helpers of the predictor
    // ------------------------------------------------------------------------

    // Signed 64-bit addition that sticks at the limits instead of wrapping.
    function automatic longint sat_sum(input longint a, input longint b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? ACC_MIN : ACC_MAX;
        end
        return s[63:0];
    endfunction

    function automatic longint clamp_bits(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // Round half up back to sample scale, then clamp to a 32-bit stage output.
    function automatic longint scale_round(input longint acc);
        longint r;
        r = sat_sum(acc, longint'(1) <<< (FRAC - 1));
        r = r >>> FRAC;
        return clamp_bits(r, COEF_W);
    endfunction

    // One pass of the cascade: the shelving stage, then the high-pass stage
    // with its fixed 1, -2, 1 numerator. Histories advance as a side effect.
    function automatic logic signed [SW-1:0] filter_sample(input logic signed [SW-1:0] x_in);
        longint x;
        longint unity;
        longint acc;
        longint y_pre;
        longint y_hp;
        x     = x_in;
        unity = longint'(1) <<< FRAC;

        acc   = x * coef_q[REG_PRE_B0];
        acc   = sat_sum(acc, pre_x_d[0] * coef_q[REG_PRE_B1]);
        acc   = sat_sum(acc, pre_x_d[1] * coef_q[REG_PRE_B2]);
        acc   = sat_sum(acc, -(pre_y_d[0] * coef_q[REG_PRE_A1]));
        acc   = sat_sum(acc, -(pre_y_d[1] * coef_q[REG_PRE_A2]));
        y_pre = scale_round(acc);

        acc   = y_pre * unity;
        acc   = sat_sum(acc, -(hp_x_d[0] * (2 * unity)));
        acc   = sat_sum(acc, hp_x_d[1] * unity);
        acc   = sat_sum(acc, -(hp_y_d[0] * coef_q[REG_HP_A1]));
        acc   = sat_sum(acc, -(hp_y_d[1] * coef_q[REG_HP_A2]));
        y_hp  = scale_round(acc);

        pre_x_d[1] = pre_x_d[0];
        pre_x_d[0] = x;
        pre_y_d[1] = pre_y_d[0];
        pre_y_d[0] = y_pre;
        hp_x_d[1]  = hp_x_d[0];
        hp_x_d[0]  = y_pre;
        hp_y_d[1]  = hp_y_d[0];
        hp_y_d[0]  = y_hp;

        return SW'(clamp_bits(y_hp, SW));
    endfunction

    // ------------------------------------------------------------------------
    // Sender: offers queued items, predicts on every accepted one.
    // ------------------------------------------------------------------------
    // The gap drawn when an item is put on the channel is served after that
    // item has been taken. Valid stays high across back-to-back items.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sample_bus.valid    <= 1'b0;
            sample_bus.audio_in <= '0;
            send_gap            <= 0;
        end
        else begin
            if (sample_bus.valid && sample_bus.ready) begin
                expected_weighted.insert(expected_weighted.size(),
                                         filter_sample(sample_bus.audio_in));
            end
            if (!sample_bus.valid || sample_bus.ready) begin
                if (send_gap != 0) begin
                    sample_bus.valid <= 1'b0;
                    send_gap         <= send_gap - 1;
                end
                else if (!send_hold && samples_to_send.size() != 0) begin
                    sample_bus.valid    <= 1'b1;
                    sample_bus.audio_in <= samples_to_send.pop_front();
                    send_gap            <= $urandom_range(0, send_gap_max);
                end
                else begin
                    sample_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: takes weighted items, compares against the oldest prediction.
    // ------------------------------------------------------------------------
    // After every item taken, ready drops for a drawn number of cycles, so the
    // block's final step sees both a free and a still-occupied output.
    always @(posedge clk or negedge rst_n) begin : receive
        int unsigned          stall;
        logic signed [SW-1:0] want;
        if (!rst_n) begin
            result_bus.ready <= 1'b0;
            sink_hold_cycles <= 0;
        end
        else begin
            if (result_bus.valid && result_bus.ready) begin
                if (expected_weighted.size() == 0) begin
                    $display("%0t: weighted_out %0d arrived with no item outstanding",
                             $time, result_bus.weighted_out);
                    failures++;
                end
                else begin
                    want = expected_weighted.pop_front();
                    if (result_bus.weighted_out !== want) begin
                        $display("%0t: weighted_out mismatch: expected %0d, actual %0d",
                                 $time, want, result_bus.weighted_out);
                        failures++;
                    end
                end
                stall            = $urandom_range(0, sink_stall_max);
                sink_hold_cycles <= stall;
                result_bus.ready <= (stall == 0);
            end
            else if (sink_hold_cycles != 0) begin
                sink_hold_cycles <= sink_hold_cycles - 1;
                result_bus.ready <= (sink_hold_cycles == 1);
            end
            else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing tasks
    // ------------------------------------------------------------------------

    // Appends one item at the tail of the send queue.
    task automatic enqueue_sample(input logic signed [SW-1:0] s);
        samples_to_send.insert(samples_to_send.size(), s);
    endtask

    // Returns at a falling edge once nothing is queued, on the channel or
    // owed by the block. With one result per item that means the block is
    // back at its input step.
    task automatic wait_idle();
        do begin
            @(negedge clk);
        end while (samples_to_send.size() != 0 || sample_bus.valid ||
                   expected_weighted.size() != 0);
    endtask

    // One coefficient write; the shadow bank follows only mapped indexes.
    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx,
                              input logic signed [COEF_W-1:0] val);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do begin
            @(posedge clk);
        end while (!(cfg_bus.valid && cfg_bus.ready));
        cfg_bus.valid <= 1'b0;
        if (idx < NUM_COEF) begin
            coef_q[idx] = val;
        end
    endtask

    // Appends random items in short runs of one shape each: broadband noise,
    // quiet signal, full-scale and near-zero corners, steps, full-scale Nyquist.
    task automatic queue_samples(input int unsigned count);
        int unsigned          made;
        int unsigned          seg_len;
        int unsigned          j;
        sample_pattern_t      pat;
        logic signed [SW-1:0] held;
        logic signed [SW-1:0] s;
        made = 0;
        while (made < count) begin
            seg_len = $urandom_range(1, 16);
            pat     = sample_pattern_t'($urandom_range(0, 5) % 5);
            held    = SW'($urandom);
            for (j = 0; j < seg_len && made < count; j++) begin
                case (pat)
                    PAT_NOISE:   s = SW'($urandom);
                    PAT_QUIET:   s = SW'(int'($urandom_range(0, 4095)) - 2048);
                    PAT_EDGE: begin
                        case ($urandom_range(0, 4))
                            0:       s = SAMPLE_MAX;
                            1:       s = SAMPLE_MIN;
                            2:       s = '0;
                            3:       s = '1;
                            default: s = 1;
                        endcase
                    end
                    PAT_STEP:    s = held;
                    default:     s = j[0] ? SAMPLE_MIN : SAMPLE_MAX;
                endcase
                enqueue_sample(s);
                made++;
            end
        end
    endtask

    // Fills the queue while the sender is held, lets it go, and waits until
    // every weighted item of the phase has been taken.
    task automatic run_phase(input int unsigned count, input int unsigned gap_max,
                             input int unsigned stall_max);
        @(posedge clk);
        send_gap_max   <= gap_max;
        sink_stall_max <= stall_max;
        queue_samples(count);
        @(posedge clk);
        send_hold <= 1'b0;
        wait_idle();
        @(posedge clk);
        send_hold <= 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int i;
        rst_n               = 1'b0;
        send_hold           = 1'b1;
        send_gap_max        = 4;
        sink_stall_max      = 4;
        failures            = 0;
        sample_bus.valid    = 1'b0;
        sample_bus.audio_in = '0;
        result_bus.ready    = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = '0;
        cfg_bus.data        = '0;

        // After reset the block holds the standard 48 kHz set and clear
        // histories.
        for (i = 0; i < NUM_COEF; i++) begin
            coef_q[i] = RESET_Q28[i];
        end
        for (i = 0; i < 2; i++) begin
            pre_x_d[i] = 0;
            pre_y_d[i] = 0;
            hp_x_d[i]  = 0;
            hp_y_d[i]  = 0;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening on the reset coefficients: silence, a full-scale
        // impulse and its decay, a full-scale Nyquist burst that drives the
        // high-pass stage into output clamping, and the small values and bit
        // patterns around zero.
        enqueue_sample('0);
        enqueue_sample(SAMPLE_MAX);
        enqueue_sample('0);
        enqueue_sample('0);
        enqueue_sample(SAMPLE_MIN);
        enqueue_sample('0);
        for (i = 0; i < 8; i++) begin
            enqueue_sample(i[0] ? SAMPLE_MIN : SAMPLE_MAX);
        end
        enqueue_sample(1);
        enqueue_sample('1);
        enqueue_sample(SW'(24'h555555));
        enqueue_sample(SW'(24'hAAAAAA));
        enqueue_sample(SAMPLE_MAX);
        enqueue_sample(SAMPLE_MAX);
        enqueue_sample(SAMPLE_MAX);
        enqueue_sample(SAMPLE_MIN);
        enqueue_sample(SAMPLE_MIN);
        enqueue_sample('0);
        run_phase(350, 4, 4);

        // Every register gets an arbitrary value; most such sets are
        // unstable, so the stage clamps see plenty of traffic.
        for (i = 0; i < NUM_COEF; i++) begin
            write_coef(reg_idx_t'(i), $urandom);
        end
        run_phase(300, 4, 4);

        // All taps at the positive limit: the products reach 2^62 and the
        // 64-bit accumulator saturates in both directions.
        for (i = 0; i < NUM_COEF; i++) begin
            write_coef(reg_idx_t'(i), 32'sh7FFF_FFFF);
        end
        run_phase(150, 2, 4);

        // All taps at the negative limit.
        for (i = 0; i < NUM_COEF; i++) begin
            write_coef(reg_idx_t'(i), 32'sh8000_0000);
        end
        run_phase(150, 4, 0);

        // Back to the standard set, then a write to the unmapped index that
        // must leave it untouched. This phase runs with no idling at all.
        for (i = 0; i < NUM_COEF; i++) begin
            write_coef(reg_idx_t'(i), COEF_W'(RESET_Q28[i]));
        end
        write_coef(REG_UNMAPPED, $urandom);
        run_phase(300, 0, 0);

        // Unity pre-filter and no high-pass feedback: the output is the plain
        // second difference of the input.
        write_coef(REG_PRE_B0, 32'sh1000_0000);
        write_coef(REG_PRE_B1, '0);
        write_coef(REG_PRE_B2, '0);
        write_coef(REG_PRE_A1, '0);
        write_coef(REG_PRE_A2, '0);
        write_coef(REG_HP_A1, '0);
        write_coef(REG_HP_A2, '0);
        run_phase(200, 4, 4);

        // Random taps within plus or minus one, mostly well-behaved filters.
        for (i = 0; i < NUM_COEF; i++) begin
            write_coef(reg_idx_t'(i),
                       COEF_W'(int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000));
        end
        run_phase(350, 4, 2);

        // Give a stray extra item time to show up before the verdict.
        repeat (40) @(posedge clk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end
        else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // A correct run takes a little over half a millisecond of simulated time.
    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/kwbq_pkg.sv
rtl/kwbq_in_if.sv
rtl/kwbq_out_if.sv
rtl/kwbq_cfg_if.sv
rtl/kwbq_coef_bank.sv
rtl/kwbq_ucode_seq.sv
rtl/kwbq_datapath.sv
rtl/k_weighting_biquad_cascade_core.sv
tb/tb_k_weighting_biquad_cascade_core.sv
